[sv/nhe_pkg.sv]
// ----------------------------------------------------------------------------
// nhe_pkg
// Shared types, constants and codes for the normalized histogram engine.
// ----------------------------------------------------------------------------
package nhe_pkg;

    localparam int NUM_BINS_DEF = 4096;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_COUNT = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [1:0] REG_VMIN  = 2'd0;
    localparam logic [1:0] REG_VMAX  = 2'd1;
    localparam logic [1:0] REG_CW    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_SETUP,
        S_SUM,
        S_DIV,
        S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic take_in;
        logic clr_start;
        logic setup;
        logic sum_step;
        logic div_start;
        logic div_step;
        logic out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic sum_done;
        logic div_done;
        logic bad_index;
        logic empty;
    } stat_t;

endpackage

[sv/nhe_if.sv]
// ----------------------------------------------------------------------------
// nhe_in_if / nhe_out_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface nhe_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [15:0] pixel_value;
    logic [11:0]        coarse_index;
    modport source (output valid, mode, pixel_value, coarse_index, input ready);
    modport sink   (input valid, mode, pixel_value, coarse_index, output ready);
endinterface

interface nhe_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] bin_fraction;
    logic [31:0] bin_sum;
    logic [31:0] total_pixels;
    logic [31:0] dropped_pixels;
    logic [1:0]  status;
    modport source (output valid, bin_fraction, bin_sum, total_pixels,
                    dropped_pixels, status, input ready);
    modport sink   (input valid, bin_fraction, bin_sum, total_pixels,
                    dropped_pixels, status, output ready);
endinterface

[sv/nhe_ctrl.sv]
// ----------------------------------------------------------------------------
// nhe_ctrl
// Sequencer for clear sweeps, pixel updates and coarse-bin readout.
// ----------------------------------------------------------------------------
module nhe_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          in_mode,
    input  logic                out_busy,
    input  nhe_pkg::stat_t      stat,
    output logic                in_ready,
    output nhe_pkg::cmd_t       cmd
);

    nhe_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nhe_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nhe_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_mode == nhe_pkg::MODE_CLEAR)
                        state_next = nhe_pkg::S_CLEAR;
                    else if (in_mode == nhe_pkg::MODE_READ)
                        state_next = nhe_pkg::S_SETUP;
                end
            end
            nhe_pkg::S_CLEAR:
                if (stat.clr_done) state_next = nhe_pkg::S_IDLE;
            nhe_pkg::S_SETUP:
                state_next = stat.bad_index ? nhe_pkg::S_OUT : nhe_pkg::S_SUM;
            nhe_pkg::S_SUM:
                if (stat.sum_done)
                    state_next = stat.empty ? nhe_pkg::S_OUT : nhe_pkg::S_DIV;
            nhe_pkg::S_DIV:
                if (stat.div_done) state_next = nhe_pkg::S_OUT;
            nhe_pkg::S_OUT:
                if (!out_busy) state_next = nhe_pkg::S_IDLE;
            default:
                state_next = nhe_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            nhe_pkg::S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.take_in   = in_valid;
                cmd.clr_start = in_valid && (in_mode == nhe_pkg::MODE_CLEAR);
            end
            nhe_pkg::S_CLEAR: ;
            nhe_pkg::S_SETUP: cmd.setup    = 1'b1;
            nhe_pkg::S_SUM:
            begin
                cmd.sum_step  = 1'b1;
                cmd.div_start = stat.sum_done;
            end
            nhe_pkg::S_DIV:   cmd.div_step = 1'b1;
            nhe_pkg::S_OUT:   cmd.out_load = !out_busy;
            default: ;
        endcase
    end

endmodule

[sv/nhe_dp.sv]
// ----------------------------------------------------------------------------
// nhe_dp
// Bin memory, counters, window accumulator, divider and result register.
// ----------------------------------------------------------------------------
module nhe_dp
#(
    parameter int NUM_BINS = nhe_pkg::NUM_BINS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  nhe_pkg::cmd_t       cmd,
    output nhe_pkg::stat_t      stat,
    input  logic [1:0]          in_mode,
    input  logic signed [15:0]  in_pixel,
    input  logic [11:0]         in_index,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_idx,
    input  logic [15:0]         cfg_data,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [15:0]         out_fraction,
    output logic [31:0]         out_sum,
    output logic [31:0]         out_total,
    output logic [31:0]         out_dropped,
    output logic [1:0]          out_status
);

    localparam int AW = $clog2(NUM_BINS);
    localparam int CW = AW + 1;   // holds NUM_BINS itself

    logic signed [15:0] vmin_reg, vmax_reg;
    logic [12:0]        cw_reg;
    logic [31:0]        mem [NUM_BINS];
    logic [31:0]        total_reg, drop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vmin_reg <= '0;
            vmax_reg <= 16'sd4095;
            cw_reg   <= 13'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                nhe_pkg::REG_VMIN: vmin_reg <= cfg_data;
                nhe_pkg::REG_VMAX: vmax_reg <= cfg_data;
                nhe_pkg::REG_CW:   cw_reg   <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // pixel bin offset
    logic signed [17:0] off;
    logic               px_in;
    assign off   = 18'(in_pixel) - 18'(vmin_reg);
    assign px_in = (in_pixel >= vmin_reg) && (in_pixel <= vmax_reg) &&
                   (off < 18'sd0 + 18'(NUM_BINS));

    // count pipeline: read, then increment and write
    logic          upd_reg;
    logic [AW-1:0] upd_addr_reg;
    logic [31:0]   rd_reg;
    logic [31:0]   upd_val;
    logic [CW-1:0] clr_cnt_reg;
    logic          clr_run_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] k_reg;
    logic          sum_rd_reg;

    assign rd_addr = cmd.sum_step ? k_reg : off[AW-1:0];
    assign upd_val = (rd_reg == '1) ? rd_reg : rd_reg + 32'd1;

    always_ff @(posedge clk)
    begin
        // forward the update in flight to a back-to-back count of the same bin
        if (upd_reg && (upd_addr_reg == rd_addr))
            rd_reg <= upd_val;
        else
            rd_reg <= mem[rd_addr];
        if (clr_run_reg)
            mem[clr_cnt_reg[AW-1:0]] <= '0;
        else if (upd_reg)
            mem[upd_addr_reg] <= upd_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upd_reg      <= 1'b0;
            upd_addr_reg <= '0;
            total_reg    <= '0;
            drop_reg     <= '0;
            clr_run_reg  <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            upd_reg      <= cmd.take_in && (in_mode == nhe_pkg::MODE_COUNT) && px_in;
            upd_addr_reg <= off[AW-1:0];
            if (cmd.clr_start)
            begin
                total_reg   <= '0;
                drop_reg    <= '0;
                clr_run_reg <= 1'b1;
                clr_cnt_reg <= '0;
            end
            else if (clr_run_reg)
            begin
                if (clr_cnt_reg == CW'(NUM_BINS - 1))
                    clr_run_reg <= 1'b0;
                clr_cnt_reg <= clr_cnt_reg + CW'(1);
            end
            else if (cmd.take_in && in_mode == nhe_pkg::MODE_COUNT)
            begin
                if (px_in)
                    total_reg <= (total_reg == '1) ? total_reg : total_reg + 32'd1;
                else
                    drop_reg <= (drop_reg == '1) ? drop_reg : drop_reg + 32'd1;
            end
        end
    end
    assign stat.clr_done = !clr_run_reg;

    // readout setup
    logic [11:0]   idx_reg;
    logic [12:0]   cwe;
    logic [16:0]   span;
    logic [CW-1:0] f_bins;
    logic [24:0]   start_w, end_w;
    logic [CW-1:0] end_reg;
    logic          bad_reg;

    assign cwe  = (cw_reg == '0) ? 13'd1 : cw_reg;
    assign span = 17'($signed({vmax_reg[15], vmax_reg}) - $signed({vmin_reg[15], vmin_reg})) + 17'd1;
    assign f_bins = (vmax_reg < vmin_reg) ? '0 :
                    (span > 17'(NUM_BINS)) ? CW'(NUM_BINS) : CW'(span);
    assign start_w = 25'(idx_reg) * 25'(cwe);
    assign end_w   = start_w + 25'(cwe);

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
            idx_reg <= in_index;
    end

    logic [32:0] acc_reg;
    logic        acc_sat_reg;
    logic [CW-1:0] kk_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            bad_reg    <= (start_w >= 25'(f_bins));
            end_reg    <= (end_w > 25'(f_bins)) ? f_bins : CW'(end_w);
            kk_reg     <= CW'(start_w);
            k_reg      <= start_w[AW-1:0];
            acc_reg    <= '0;
            acc_sat_reg <= 1'b0;
            sum_rd_reg <= 1'b0;
        end
        else if (cmd.sum_step)
        begin
            // the read of bin k is registered and lands in the next cycle
            if (kk_reg != end_reg)
            begin
                kk_reg <= kk_reg + CW'(1);
                k_reg  <= k_reg + AW'(1);
            end
            sum_rd_reg <= (kk_reg != end_reg);
            if (sum_rd_reg && !acc_sat_reg)
            begin
                if (acc_reg + 33'(rd_reg) > 33'hFFFFFFFF)
                    acc_sat_reg <= 1'b1;
                acc_reg <= acc_reg + 33'(rd_reg);
            end
        end
    end
    logic [31:0] sum32;
    assign sum32 = acc_sat_reg ? '1 : acc_reg[31:0];
    assign stat.bad_index = (start_w >= 25'(f_bins));
    assign stat.sum_done  = (kk_reg == end_reg) && !sum_rd_reg;
    assign stat.empty     = (total_reg == '0);

    // restoring divider: (sum32 << 16) / total, one quotient bit a cycle
    logic [48:0] rem_reg;
    logic [47:0] num_reg;
    logic [47:0] q_reg;
    logic [5:0]  dcnt_reg;
    logic [48:0] trial;
    assign trial = {rem_reg[47:0], num_reg[47]};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg  <= '0;
            num_reg  <= {sum32, 16'd0};
            q_reg    <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step && dcnt_reg != 6'd48)
        begin
            num_reg  <= {num_reg[46:0], 1'b0};
            dcnt_reg <= dcnt_reg + 6'd1;
            if (trial >= 49'(total_reg))
            begin
                rem_reg <= trial - 49'(total_reg);
                q_reg   <= {q_reg[46:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[46:0], 1'b0};
            end
        end
    end
    assign stat.div_done = (dcnt_reg == 6'd48);

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.out_load)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_total   <= total_reg;
            out_dropped <= drop_reg;
            if (bad_reg)
            begin
                out_status   <= nhe_pkg::ST_RANGE;
                out_sum      <= '0;
                out_fraction <= '0;
            end
            else if (total_reg == '0)
            begin
                out_status   <= nhe_pkg::ST_EMPTY;
                out_sum      <= sum32;
                out_fraction <= '0;
            end
            else
            begin
                out_status   <= nhe_pkg::ST_OK;
                out_sum      <= sum32;
                out_fraction <= (q_reg > 48'd65535) ? 16'hFFFF : q_reg[15:0];
            end
        end
    end

endmodule

[sv/normalized_histogram_engine.sv]
// ----------------------------------------------------------------------------
// normalized_histogram_engine
// Pixel histogram with clipped coarse-bin readout and Q0.16 share.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in      | in  | mode, pixel_value, coarse_index
//  out     | out | bin_fraction, bin_sum, total_pixels, dropped_pixels, status
//  cfg     | in  | cfg_we, cfg_index, cfg_data
//
// Count and unused-mode requests are taken back to back; a count is a
// registered read then a write, with the pending update forwarded to a read of
// the same bin. Clear wipes one bin a cycle and holds the input meanwhile;
// after reset a clearing pass over every bin runs before requests are taken.
// A read walks its window's bins and runs the 48-step divider, then presents
// its result; an empty histogram skips the divider, an index past the end both.
// A stalled result holds the controller in its output state, and the input too.
module normalized_histogram_engine
#(
    parameter int NUM_BINS = nhe_pkg::NUM_BINS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    nhe_in_if.sink      in,
    nhe_out_if.source   out,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    nhe_pkg::cmd_t  cmd;
    nhe_pkg::stat_t stat;
    logic           rdy;

    // hold off requests during the clearing pass
    logic           busy_clr;
    assign busy_clr = !stat.clr_done;
    assign in.ready = rdy && !busy_clr;

    nhe_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in.valid && !busy_clr),
        .in_mode  (in.mode),
        .out_busy (out.valid && !out.ready),
        .stat     (stat),
        .in_ready (rdy),
        .cmd      (cmd)
    );

    nhe_dp #(.NUM_BINS(NUM_BINS)) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_mode      (in.mode),
        .in_pixel     (in.pixel_value),
        .in_index     (in.coarse_index),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_index),
        .cfg_data     (cfg_data),
        .out_ready    (out.ready),
        .out_valid    (out.valid),
        .out_fraction (out.bin_fraction),
        .out_sum      (out.bin_sum),
        .out_total    (out.total_pixels),
        .out_dropped  (out.dropped_pixels),
        .out_status   (out.status)
    );

endmodule

[dv/normalized_histogram_engine_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// normalized_histogram_engine_test
// Self-checking bench for the histogram engine: counts, clears and coarse
// readouts are predicted per request and every result is compared field by
// field, across several range and coarse-width settings and idle patterns.
// ----------------------------------------------------------------------------
module normalized_histogram_engine_test;

    localparam int          BINS        = nhe_pkg::NUM_BINS_DEF;
    localparam logic [1:0]  MODE_UNUSED = 2'd3;
    localparam int          DRAIN_WAIT  = BINS + 200;
    localparam longint      CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [1:0]         mode;
        logic signed [15:0] pixel;
        logic [11:0]        index;
    } hist_req_t;

    typedef struct {
        logic [15:0] fraction;
        logic [31:0] sum;
        logic [31:0] total;
        logic [31:0] dropped;
        logic [1:0]  status;
    } bin_result_t;

    logic clk;
    logic rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    nhe_in_if  in_if();
    nhe_out_if out_if();

    normalized_histogram_engine u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (in_if),
        .out       (out_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [31:0] hist_bins [BINS];
    logic [31:0] hist_total;
    logic [31:0] hist_dropped;
    int          cur_vmin;
    int          cur_vmax;
    int unsigned cur_cw;

    hist_req_t   pending_reqs [$];
    bin_result_t expected_bins [$];

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  recv_hold;
    int  fail_count;
    int  reads_checked;
    int  counts_sent;
    int  clears_sent;
    int  phases_run;
    longint cycle_count = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned fine_count();
        int span;
        if (cur_vmax < cur_vmin)
            return 0;
        span = cur_vmax - cur_vmin + 1;
        return (span > BINS) ? BINS : span;
    endfunction

    function automatic bin_result_t predict_readout(logic [11:0] idx);
        bin_result_t r;
        int unsigned cw;
        int unsigned f;
        int unsigned ncoarse;
        int unsigned first;
        int unsigned last;
        longint unsigned acc;
        longint unsigned q;
        cw = (cur_cw == 0) ? 1 : cur_cw;
        f = fine_count();
        ncoarse = (f == 0) ? 0 : (f - 1) / cw + 1;
        r.fraction = '0;
        r.sum = '0;
        r.total = hist_total;
        r.dropped = hist_dropped;
        if (idx >= ncoarse)
            r.status = nhe_pkg::ST_RANGE;
        else
        begin
            first = idx * cw;
            last = first + cw;
            if (last > f)
                last = f;
            acc = 0;
            for (int unsigned k = first; k < last; k++)
                acc += hist_bins[k];
            r.sum = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
            if (hist_total == 0)
                r.status = nhe_pkg::ST_EMPTY;
            else
            begin
                q = ({32'd0, r.sum} << 16) / hist_total;
                r.fraction = (q > 65535) ? 16'hFFFF : q[15:0];
                r.status = nhe_pkg::ST_OK;
            end
        end
        return r;
    endfunction

    task automatic apply_request(hist_req_t rq);
        int px;
        int unsigned b;
        px = rq.pixel;
        case (rq.mode)
            nhe_pkg::MODE_CLEAR:
            begin
                for (int k = 0; k < BINS; k++)
                    hist_bins[k] = '0;
                hist_total = '0;
                hist_dropped = '0;
                clears_sent++;
            end
            nhe_pkg::MODE_COUNT:
            begin
                counts_sent++;
                b = px - cur_vmin;
                if (px < cur_vmin || px > cur_vmax || b >= BINS)
                begin
                    if (hist_dropped != 32'hFFFF_FFFF)
                        hist_dropped++;
                end
                else
                begin
                    if (hist_bins[b] != 32'hFFFF_FFFF)
                        hist_bins[b]++;
                    if (hist_total != 32'hFFFF_FFFF)
                        hist_total++;
                end
            end
            nhe_pkg::MODE_READ:
                expected_bins = {expected_bins, predict_readout(rq.index)};
            default: ;
        endcase
    endtask

    // driver: offer the next pending request, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        hist_req_t rq;
        if (!rst_n)
        begin
            in_if.valid <= 1'b0;
            in_if.mode <= nhe_pkg::MODE_CLEAR;
            in_if.pixel_value <= '0;
            in_if.coarse_index <= '0;
        end
        else
        begin
            if (in_if.valid && in_if.ready)
            begin
                rq.mode = in_if.mode;
                rq.pixel = in_if.pixel_value;
                rq.index = in_if.coarse_index;
                apply_request(rq);
            end
            if (!in_if.valid || in_if.ready)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    rq = pending_reqs.pop_front();
                    in_if.valid <= 1'b1;
                    in_if.mode <= rq.mode;
                    in_if.pixel_value <= rq.pixel;
                    in_if.coarse_index <= rq.index;
                end
                else
                    in_if.valid <= 1'b0;
            end
        end
    end

    // monitor: check each result against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        bin_result_t e;
        if (!rst_n)
            out_if.ready <= 1'b0;
        else
        begin
            if (out_if.valid && out_if.ready)
            begin
                if (expected_bins.size() == 0)
                begin
                    $error("result with no request waiting");
                    fail_count++;
                end
                else
                begin
                    e = expected_bins.pop_front();
                    reads_checked++;
                    if (out_if.bin_fraction !== e.fraction)
                    begin
                        $error("bin_fraction: expected %0d, actual %0d",
                               e.fraction, out_if.bin_fraction);
                        fail_count++;
                    end
                    if (out_if.bin_sum !== e.sum)
                    begin
                        $error("bin_sum: expected %0d, actual %0d", e.sum, out_if.bin_sum);
                        fail_count++;
                    end
                    if (out_if.total_pixels !== e.total)
                    begin
                        $error("total_pixels: expected %0d, actual %0d",
                               e.total, out_if.total_pixels);
                        fail_count++;
                    end
                    if (out_if.dropped_pixels !== e.dropped)
                    begin
                        $error("dropped_pixels: expected %0d, actual %0d",
                               e.dropped, out_if.dropped_pixels);
                        fail_count++;
                    end
                    if (out_if.status !== e.status)
                    begin
                        $error("status: expected %0d, actual %0d", e.status, out_if.status);
                        fail_count++;
                    end
                end
            end
            out_if.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            nhe_pkg::REG_VMIN: cur_vmin = $signed(data);
            nhe_pkg::REG_VMAX: cur_vmax = $signed(data);
            default:           cur_cw = data[12:0];
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_range(int vmin, int vmax, int unsigned cw);
        write_reg(nhe_pkg::REG_VMIN, vmin[15:0]);
        write_reg(nhe_pkg::REG_VMAX, vmax[15:0]);
        write_reg(nhe_pkg::REG_CW, cw[15:0]);
    endtask

    task automatic push_req(logic [1:0] mode, int px, int unsigned idx);
        hist_req_t rq;
        rq.mode = mode;
        rq.pixel = px[15:0];
        rq.index = idx[11:0];
        pending_reqs = {pending_reqs, rq};
    endtask

    // hold until every request is taken and every result has come back
    task automatic drain();
        while (pending_reqs.size() != 0 || in_if.valid || expected_bins.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic random_phase(int n, int read_pct);
        int unsigned f;
        int unsigned cw;
        int unsigned nc;
        int unsigned r;
        int px;
        f = fine_count();
        cw = (cur_cw == 0) ? 1 : cur_cw;
        nc = (f == 0) ? 0 : (f - 1) / cw + 1;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < read_pct)
            begin
                if ($urandom_range(9) == 0)
                    push_req(nhe_pkg::MODE_READ, $urandom, $urandom_range(4095));
                else
                    push_req(nhe_pkg::MODE_READ, $urandom, $urandom_range(nc + 1));
            end
            else if (r == 99)
                push_req(nhe_pkg::MODE_CLEAR, $urandom, $urandom);
            else if (r >= 95)
                push_req(MODE_UNUSED, $urandom, $urandom);
            else
            begin
                if ($urandom_range(3) == 0)
                    px = $urandom;
                else
                    px = cur_vmin - 3 + int'($urandom_range(f + 6));
                push_req(nhe_pkg::MODE_COUNT, px, $urandom);
            end
        end
        drain();
        phases_run++;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= nhe_pkg::REG_VMIN;
        cfg_data <= '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 1'b0;
        fail_count = 0;
        reads_checked = 0;
        counts_sent = 0;
        clears_sent = 0;
        phases_run = 0;
        for (int k = 0; k < BINS; k++)
            hist_bins[k] = '0;
        hist_total = '0;
        hist_dropped = '0;
        cur_vmin = 0;
        cur_vmax = 4095;
        cur_cw = 1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        // let the clearing pass after reset finish
        repeat (DRAIN_WAIT) @(posedge clk);

        // directed: edges of the range, drops, empty, full share
        set_range(0, 4095, 1);
        push_req(nhe_pkg::MODE_READ, 0, 0);
        push_req(nhe_pkg::MODE_COUNT, 0, 0);
        push_req(nhe_pkg::MODE_READ, 0, 0);
        push_req(nhe_pkg::MODE_COUNT, 4095, 0);
        push_req(nhe_pkg::MODE_COUNT, -1, 0);
        push_req(nhe_pkg::MODE_COUNT, 4096, 0);
        push_req(nhe_pkg::MODE_COUNT, 32767, 0);
        push_req(nhe_pkg::MODE_COUNT, -32768, 0);
        push_req(MODE_UNUSED, 5, 5);
        push_req(nhe_pkg::MODE_READ, 0, 4095);
        push_req(nhe_pkg::MODE_READ, 0, 4096 - 1);
        push_req(nhe_pkg::MODE_READ, 0, 12'hAAA);
        push_req(nhe_pkg::MODE_READ, 0, 12'h555);
        push_req(nhe_pkg::MODE_CLEAR, 0, 0);
        push_req(nhe_pkg::MODE_READ, 0, 0);
        push_req(nhe_pkg::MODE_COUNT, 16'h5555, 0);
        push_req(nhe_pkg::MODE_COUNT, 16'h2AAA, 0);
        push_req(nhe_pkg::MODE_READ, 0, 12'h555);
        drain();

        set_range(-100, 200, 7);
        send_idle_pct = 82;
        random_phase(250, 14);

        set_range(1000, 999, 3);
        send_idle_pct = 0;
        recv_stall_pct = 82;
        random_phase(200, 14);

        set_range(-32768, 32767, 0);
        send_idle_pct = 16;
        recv_stall_pct = 16;
        random_phase(300, 14);

        // widest window: reads walk every in-range bin, keep them few
        set_range(30000, 32767, 4096);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_phase(150, 3);

        // receiver holds off while reads pile up behind the busy engine
        set_range(-50, 50, 13);
        for (int i = 0; i < 60; i++)
            push_req(nhe_pkg::MODE_COUNT, -52 + int'($urandom_range(104)), 0);
        for (int i = 0; i < 30; i++)
            push_req(nhe_pkg::MODE_READ, 0, $urandom_range(8));
        fork
            begin
                recv_hold = 1'b1;
                repeat (600) @(posedge clk);
                recv_hold = 1'b0;
            end
        join_none
        random_phase(250, 14);

        set_range(-32768, -32000, 64);
        send_idle_pct = 16;
        recv_stall_pct = 16;
        random_phase(300, 14);

        set_range(-2, 2, 4);
        send_idle_pct = 82;
        recv_stall_pct = 82;
        random_phase(250, 20);

        $display("Covered %0d phases: %0d counts, %0d clears, %0d readouts checked",
                 phases_run, counts_sent, clears_sent, reads_checked);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
